// File: hdl/elr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package elr_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_OUTER_CENTER = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OUTER_RADII  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INNER_CENTER = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INNER_RADII  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RED_DELTA    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GREEN_DELTA  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BLUE_DELTA   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_STRENGTH     = 3'd7;

  localparam logic [7:0] STRENGTH_RESET = 8'd100;

  // Division by 100 as a multiply by ceil(2^23/100); exact for products below 91180.
  localparam int          RecipShift = 23;
  localparam logic [16:0] RECIP_100  = 17'd83887;

  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [10:0]        rx;
    logic [10:0]        ry;
  } ellipse_t;

  typedef struct packed {
    logic [7:0] lift;
    logic [7:0] drop;
  } light_t;

endpackage

`default_nettype wire

// File: hdl/elr_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module elr_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [elr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [elr_pkg::CfgDataW-1:0]  cfg_data,
  output elr_pkg::ellipse_t                  outer_geom,
  output elr_pkg::ellipse_t                  inner_geom,
  output logic signed [8:0]                  red_delta,
  output logic signed [8:0]                  green_delta,
  output logic signed [8:0]                  blue_delta,
  output logic [7:0]                         strength
);

  logic [23:0] outer_center;
  logic [21:0] outer_radii;
  logic [23:0] inner_center;
  logic [21:0] inner_radii;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_center <= '0;
      outer_radii  <= '0;
      inner_center <= '0;
      inner_radii  <= '0;
      red_delta    <= '0;
      green_delta  <= '0;
      blue_delta   <= '0;
      strength     <= elr_pkg::STRENGTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        elr_pkg::REG_OUTER_CENTER: outer_center <= cfg_data[23:0];
        elr_pkg::REG_OUTER_RADII:  outer_radii  <= cfg_data[21:0];
        elr_pkg::REG_INNER_CENTER: inner_center <= cfg_data[23:0];
        elr_pkg::REG_INNER_RADII:  inner_radii  <= cfg_data[21:0];
        elr_pkg::REG_RED_DELTA:    red_delta    <= $signed(cfg_data[8:0]);
        elr_pkg::REG_GREEN_DELTA:  green_delta  <= $signed(cfg_data[8:0]);
        elr_pkg::REG_BLUE_DELTA:   blue_delta   <= $signed(cfg_data[8:0]);
        elr_pkg::REG_STRENGTH:     strength     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    outer_geom.cx = $signed(outer_center[11:0]);
    outer_geom.cy = $signed(outer_center[23:12]);
    outer_geom.rx = outer_radii[10:0];
    outer_geom.ry = outer_radii[21:11];
    inner_geom.cx = $signed(inner_center[11:0]);
    inner_geom.cy = $signed(inner_center[23:12]);
    inner_geom.rx = inner_radii[10:0];
    inner_geom.ry = inner_radii[21:11];
  end

endmodule

`default_nettype wire

// File: hdl/elr_gain.sv
`timescale 1ns / 1ps
`default_nettype none

// Turns a signed channel delta and the strength into a lift and a drop, both
// clamped to 255. Three register stages. The user must hold inputs static while pixels flow (not enforced).
module elr_gain (
  input  wire logic              clk,
  input  wire logic signed [8:0] delta,
  input  wire logic [7:0]        strength,
  output elr_pkg::light_t        light
);

  logic [8:0]  mag;
  logic [16:0] prod;
  logic        neg1;
  logic [33:0] scaled;
  logic [10:0] quot;
  logic        neg2;

  // A delta of -256 gives a magnitude of 256, which the unsigned view keeps.
  assign mag    = delta[8] ? 9'(-delta) : delta[8:0];
  assign scaled = {17'b0, prod} * {17'b0, elr_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    prod <= {8'b0, mag} * {9'b0, strength};
    neg1 <= delta[8];
    quot <= scaled[elr_pkg::RecipShift +: 11];
    neg2 <= neg1;
    if (neg2) begin
      light.lift <= 8'd0;
      light.drop <= (quot > 11'd255) ? 8'hFF : quot[7:0];
    end else begin
      light.lift <= (quot > 11'd255) ? 8'hFF : quot[7:0];
      light.drop <= 8'd0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/elr_span.sv
`timescale 1ns / 1ps
`default_nettype none

// Five-stage test of whether a pixel lies in the row span of one ellipse:
// |dy| <= ry, and either dx == 0 or (2|dx|-1)^2 * ry^2 <= 4 * rx^2 * (ry^2 - dy^2).
module elr_span (
  input  wire logic              clk,
  input  wire logic [9:0]        pix_x,
  input  wire logic [9:0]        pix_y,
  input  wire elr_pkg::ellipse_t geom,
  output logic                   hit
);

  logic signed [12:0] dx_s;
  logic signed [12:0] dy_s;
  logic [11:0]        adx;
  logic [11:0]        ady;

  logic [12:0]        t;
  logic [25:0]        t2;
  logic [23:0]        dy2;
  logic [21:0]        rx2;
  logic [21:0]        ry2;
  logic               dy_out2;
  logic               dx_zero2;

  logic [25:0]        t2_3;
  logic [21:0]        rx2_3;
  logic [21:0]        ry2_3;
  logic [21:0]        diff3;
  logic               dy_out3;
  logic               dx_zero3;

  logic [47:0]        lhs4;
  logic [43:0]        rhs4;
  logic               dy_out4;
  logic               dx_zero4;

  assign dx_s = $signed({3'b0, pix_x}) - $signed({geom.cx[11], geom.cx});
  assign dy_s = $signed({3'b0, pix_y}) - $signed({geom.cy[11], geom.cy});
  assign t    = {adx, 1'b0} - 13'd1;

  always_ff @(posedge clk) begin
    // Stage 1: absolute offsets from the center.
    adx <= dx_s[12] ? 12'(-dx_s) : dx_s[11:0];
    ady <= dy_s[12] ? 12'(-dy_s) : dy_s[11:0];

    // Stage 2: squares.
    t2       <= {13'b0, t} * {13'b0, t};
    dy2      <= {12'b0, ady} * {12'b0, ady};
    rx2      <= {11'b0, geom.rx} * {11'b0, geom.rx};
    ry2      <= {11'b0, geom.ry} * {11'b0, geom.ry};
    dy_out2  <= ady > {1'b0, geom.ry};
    dx_zero2 <= adx == 12'd0;

    // Stage 3: vertical room left in this row. Only used when dy <= ry.
    t2_3     <= t2;
    rx2_3    <= rx2;
    ry2_3    <= ry2;
    diff3    <= dy_out2 ? 22'd0 : ry2 - dy2[21:0];
    dy_out3  <= dy_out2;
    dx_zero3 <= dx_zero2;

    // Stage 4: the two sides of the span test.
    lhs4     <= {22'b0, t2_3} * {26'b0, ry2_3};
    rhs4     <= {22'b0, rx2_3} * {22'b0, diff3};
    dy_out4  <= dy_out3;
    dx_zero4 <= dx_zero3;

    // Stage 5: compare.
    hit <= !dy_out4 && (dx_zero4 || (lhs4 <= {2'b0, rhs4, 2'b0}));
  end

endmodule

`default_nettype wire

// File: hdl/elliptic_ring_light_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Elliptic ring light blend.
// Pixels enter on start with pixel_x, pixel_y and pixel_color; a pixel is
// taken at every clock edge where start is high and busy is low, so one pixel
// per cycle streams through. busy is high only while rst is held.
// Each pixel gives one result on new_color and in_ring, marked by a one-cycle
// done strobe. The receiver cannot stall; results leave in the order the pixels
// came in.
// Pixels inside the outer ellipse and outside the inner ellipse get a per
// channel lift or drop of delta * strength / 100, saturated per byte.
// The pipeline depth is set by the span test: offsets, squares, row room, the
// 26 x 22 bit product and the final compare, one register stage each,
// followed by the output register.
// Configuration registers are written over cfg_valid / cfg_index / cfg_data;
// cfg_ready is always high. Write them only while no pixel is in flight.
// Reset clears the pipeline valid bits and loads the register reset values
// (strength 100, all else zero, which leaves every pixel unchanged).
module elliptic_ring_light_blend #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [9:0]                    pixel_x,
  input  wire logic [9:0]                    pixel_y,
  input  wire logic [31:0]                   pixel_color,
  output logic                               done,
  output logic [31:0]                        new_color,
  output logic                               in_ring,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [elr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [elr_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int          Depth = 5;
  localparam logic [11:0] XLim  = 12'(SCREEN_WIDTH);
  localparam logic [11:0] YLim  = 12'(SCREEN_HEIGHT);

  elr_pkg::ellipse_t outer_geom;
  elr_pkg::ellipse_t inner_geom;
  logic signed [8:0] red_delta;
  logic signed [8:0] green_delta;
  logic signed [8:0] blue_delta;
  logic [7:0]        strength;
  elr_pkg::light_t   red_light;
  elr_pkg::light_t   green_light;
  elr_pkg::light_t   blue_light;

  logic              accept;
  logic              enable;
  logic              outer_hit;
  logic              inner_hit;
  logic [Depth-1:0]  valid;
  logic [Depth-1:0]  gate;
  logic [31:0]       color [Depth];
  logic [31:0]       blended;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Radii must all be nonzero and the pixel must lie on the screen.
  assign enable = (outer_geom.rx != 11'd0) && (outer_geom.ry != 11'd0) &&
                  (inner_geom.rx != 11'd0) && (inner_geom.ry != 11'd0) &&
                  ({2'b0, pixel_x} < XLim) && ({2'b0, pixel_y} < YLim);

  elr_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outer_geom  (outer_geom),
    .inner_geom  (inner_geom),
    .red_delta   (red_delta),
    .green_delta (green_delta),
    .blue_delta  (blue_delta),
    .strength    (strength)
  );

  elr_gain u_gain_red   (.clk(clk), .delta(red_delta),   .strength(strength), .light(red_light));
  elr_gain u_gain_green (.clk(clk), .delta(green_delta), .strength(strength), .light(green_light));
  elr_gain u_gain_blue  (.clk(clk), .delta(blue_delta),  .strength(strength), .light(blue_light));

  elr_span u_span_outer (
    .clk   (clk),
    .pix_x (pixel_x),
    .pix_y (pixel_y),
    .geom  (outer_geom),
    .hit   (outer_hit)
  );

  elr_span u_span_inner (
    .clk   (clk),
    .pix_x (pixel_x),
    .pix_y (pixel_y),
    .geom  (inner_geom),
    .hit   (inner_hit)
  );

  function automatic logic [7:0] blend_chan(input logic [7:0] c, input elr_pkg::light_t l);
    logic [8:0] up;
    logic [7:0] sat;
    up  = {1'b0, c} + {1'b0, l.lift};
    sat = up[8] ? 8'hFF : up[7:0];
    return (sat > l.drop) ? sat - l.drop : 8'd0;
  endfunction

  assign blended = {color[Depth-1][31:24],
                    blend_chan(color[Depth-1][23:16], red_light),
                    blend_chan(color[Depth-1][15:8], green_light),
                    blend_chan(color[Depth-1][7:0], blue_light)};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[Depth-2:0], accept};
      done  <= valid[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    color[0] <= pixel_color;
    gate     <= {gate[Depth-2:0], enable};
    for (int i = 1; i < Depth; i++) begin
      color[i] <= color[i-1];
    end
    if (gate[Depth-1] && outer_hit && !inner_hit) begin
      new_color <= blended;
      in_ring   <= 1'b1;
    end else begin
      new_color <= color[Depth-1];
      in_ring   <= 1'b0;
    end
  end

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted pixel did not produce a result after six cycles");

  a_alpha_kept : assert property (@(posedge clk) disable iff (rst)
    $past(accept, 6) && done |-> new_color[31:24] == $past(pixel_color[31:24], 6))
    else $error("top byte of the color word changed");

  a_untouched : assert property (@(posedge clk) disable iff (rst)
    $past(accept, 6) && done && !in_ring |-> new_color == $past(pixel_color, 6))
    else $error("pixel outside the ring was changed");

  a_radii_zero : assert property (@(posedge clk) disable iff (rst)
    done && in_ring |-> $past(enable, 6))
    else $error("ring reported for a disabled or off-screen pixel");
`endif

endmodule

`default_nettype wire

// File: dv/elliptic_ring_light_blend_test.sv
`timescale 1ns / 1ps

module elliptic_ring_light_blend_test;

  localparam int SCREEN_W         = 1024;
  localparam int SCREEN_H         = 1024;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_LIMIT      = 200;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RANDOM_PHASES    = 14;
  localparam int PIXELS_PER_PHASE = 140;
  localparam int PRINT_LIMIT      = 40;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [31:0] color;
  } pixel_req_t;

  typedef struct packed {
    pixel_req_t  req;
    logic [31:0] color;
    logic        ring;
  } shade_t;

  logic                         clk;
  logic                         rst;
  logic                         start       = 1'b0;
  logic [9:0]                   pixel_x     = '0;
  logic [9:0]                   pixel_y     = '0;
  logic [31:0]                  pixel_color = '0;
  logic                         busy;
  logic                         done;
  logic [31:0]                  new_color;
  logic                         in_ring;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [elr_pkg::CfgIdxW-1:0]  cfg_index;
  logic [elr_pkg::CfgDataW-1:0] cfg_data;

  // Copies of the configuration registers, updated as each write is accepted.
  logic [23:0] outer_ctr;
  logic [21:0] outer_rad;
  logic [23:0] hole_ctr;
  logic [21:0] hole_rad;
  logic [8:0]  red_dlt;
  logic [8:0]  green_dlt;
  logic [8:0]  blue_dlt;
  logic [7:0]  strength;

  pixel_req_t pixel_q[$];
  shade_t     shade_q[$];
  int         fail_count = 0;
  int         cycles     = 0;
  bit         results_due;

  // Sender state.
  pixel_req_t nxt;
  bit         accepted;
  bit         sending;
  bit         drain_pause;
  int         burst_left;
  int         gap_left;
  int         bursts_done;

  shade_t     want;

  elliptic_ring_light_blend #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .done       (done),
    .new_color  (new_color),
    .in_ring    (in_ring),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Exact span test: dy within ry, and dx == 0 or (2|dx|-1)^2*ry^2 <= 4*rx^2*(ry^2-dy^2).
  function automatic bit in_span(input logic [9:0] px, input logic [9:0] py,
                                 input logic [23:0] ctr, input logic [21:0] rad);
    longint cx, cy, rx, ry, dx, dy, t;
    cx = $signed(ctr[11:0]);
    cy = $signed(ctr[23:12]);
    rx = rad[10:0];
    ry = rad[21:11];
    dx = longint'(px) - cx;
    dy = longint'(py) - cy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dy > ry) return 1'b0;
    if (dx == 0) return 1'b1;
    t = 2 * dx - 1;
    return t * t * ry * ry <= 4 * rx * rx * (ry * ry - dy * dy);
  endfunction

  function automatic logic [7:0] light_channel(input logic [7:0] c, input logic [8:0] dlt);
    int sd, v, lift, drop, r;
    sd   = $signed(dlt);
    v    = sd * int'(strength) / 100;
    lift = (v > 0) ? v : 0;
    drop = (v < 0) ? -v : 0;
    if (lift > 255) lift = 255;
    if (drop > 255) drop = 255;
    r = int'(c) + lift;
    if (r > 255) r = 255;
    r = r - drop;
    if (r < 0) r = 0;
    return r[7:0];
  endfunction

  function automatic shade_t shade_pixel(input pixel_req_t p);
    shade_t s;
    bit     ring;
    s.req   = p;
    s.color = p.color;
    ring    = 1'b1;
    if (outer_rad[10:0] == 0 || outer_rad[21:11] == 0 ||
        hole_rad[10:0] == 0 || hole_rad[21:11] == 0)
      ring = 1'b0;
    if (p.x >= SCREEN_W || p.y >= SCREEN_H) ring = 1'b0;
    if (ring)
      ring = in_span(p.x, p.y, outer_ctr, outer_rad) && !in_span(p.x, p.y, hole_ctr, hole_rad);
    if (ring) begin
      s.color[23:16] = light_channel(p.color[23:16], red_dlt);
      s.color[15:8]  = light_channel(p.color[15:8], green_dlt);
      s.color[7:0]   = light_channel(p.color[7:0], blue_dlt);
    end
    s.ring = ring;
    return s;
  endfunction

  function automatic void queue_pixel(input int x, input int y, input logic [31:0] c);
    pixel_req_t p;
    p.x     = (x < 0) ? 10'd0 : (x > SCREEN_W - 1) ? 10'(SCREEN_W - 1) : 10'(x);
    p.y     = (y < 0) ? 10'd0 : (y > SCREEN_H - 1) ? 10'(SCREEN_H - 1) : 10'(y);
    p.color = c;
    pixel_q.push_back(p);
  endfunction

  // Outer center, outer right edge, and a point midway between hole and outer edge.
  function automatic void queue_probes();
    int cx, cy, rx, hrx;
    cx  = $signed(outer_ctr[11:0]);
    cy  = $signed(outer_ctr[23:12]);
    rx  = outer_rad[10:0];
    hrx = hole_rad[10:0];
    queue_pixel(cx, cy, 32'h80FF_0080);
    queue_pixel(cx + rx, cy, 32'h00FF_FFFF);
    queue_pixel(cx - (rx + hrx) / 2, cy, 32'hFF00_7F01);
  endfunction

  function automatic logic [21:0] random_radii();
    case ($urandom_range(0, 15))
      0:       return {11'd0, 11'($urandom_range(1, 300))};
      1:       return {11'($urandom_range(1, 300)), 11'd0};
      2:       return 22'($urandom);
      3:       return 22'h3F_FFFF;
      default: return {11'($urandom_range(1, 320)), 11'($urandom_range(1, 320))};
    endcase
  endfunction

  function automatic logic [8:0] random_delta();
    case ($urandom_range(0, 5))
      0:       return 9'h0FF;
      1:       return 9'h100;
      2:       return 9'h101;
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_color();
    logic [31:0] c;
    c = $urandom;
    for (int b = 0; b < 4; b++) begin
      case ($urandom_range(0, 5))
        0:       c[8*b +: 8] = 8'h00;
        1:       c[8*b +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic write_reg(input logic [elr_pkg::CfgIdxW-1:0] idx,
                           input logic [elr_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      elr_pkg::REG_OUTER_CENTER: outer_ctr = val[23:0];
      elr_pkg::REG_OUTER_RADII:  outer_rad = val[21:0];
      elr_pkg::REG_INNER_CENTER: hole_ctr  = val[23:0];
      elr_pkg::REG_INNER_RADII:  hole_rad  = val[21:0];
      elr_pkg::REG_RED_DELTA:    red_dlt   = val[8:0];
      elr_pkg::REG_GREEN_DELTA:  green_dlt = val[8:0];
      elr_pkg::REG_BLUE_DELTA:   blue_dlt  = val[8:0];
      elr_pkg::REG_STRENGTH:     strength  = val[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [23:0] oc, input logic [21:0] orad,
                              input logic [23:0] ic, input logic [21:0] irad,
                              input logic [8:0] dr, input logic [8:0] dg,
                              input logic [8:0] db, input logic [7:0] st);
    write_reg(elr_pkg::REG_OUTER_CENTER, oc);
    write_reg(elr_pkg::REG_OUTER_RADII, orad);
    write_reg(elr_pkg::REG_INNER_CENTER, ic);
    write_reg(elr_pkg::REG_INNER_RADII, irad);
    write_reg(elr_pkg::REG_RED_DELTA, dr);
    write_reg(elr_pkg::REG_GREEN_DELTA, dg);
    write_reg(elr_pkg::REG_BLUE_DELTA, db);
    write_reg(elr_pkg::REG_STRENGTH, st);
  endtask

  // Waits until every queued request is taken and its result has come back.
  task automatic drain_results();
    int waited;
    waited = 0;
    do @(negedge clk); while (pixel_q.size() != 0 || start);
    while (shade_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (shade_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", shade_q.size()));
      shade_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) results_due <= (shade_q.size() != 0);

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start       <= 1'b0;
      burst_left  = 1;
      gap_left    = 0;
      bursts_done = 0;
      drain_pause = 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) shade_q.push_back(shade_pixel({pixel_x, pixel_y, pixel_color}));
      sending = start && !accepted;
      if (!sending) begin
        if (drain_pause) begin
          // The request taken at this edge is not yet counted in results_due.
          if (!accepted) drain_pause = results_due;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          nxt = pixel_q.pop_front();
          pixel_x     <= nxt.x;
          pixel_y     <= nxt.y;
          pixel_color <= nxt.color;
          sending = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            bursts_done++;
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            drain_pause = (bursts_done % 16 == 7);
          end
        end
      end
      start <= sending;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(done)) begin
        report_mismatch("done strobe is unknown");
      end else if (done) begin
        if (shade_q.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with no request outstanding",
                                    new_color, in_ring));
        end else begin
          want = shade_q.pop_front();
          if (new_color !== want.color)
            report_mismatch($sformatf("pixel (%0d,%0d) color %h: new_color %h, expected %h",
                                      want.req.x, want.req.y, want.req.color,
                                      new_color, want.color));
          if (in_ring !== want.ring)
            report_mismatch($sformatf("pixel (%0d,%0d) color %h: in_ring %b, expected %b",
                                      want.req.x, want.req.y, want.req.color,
                                      in_ring, want.ring));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          cx, cy, hx, hy, ox, oy, hox, hoy, sel;
    logic [23:0] oc_n, ic_n;
    logic [21:0] or_n, ir_n;
    logic [7:0]  st_n;

    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    outer_ctr = '0;
    outer_rad = '0;
    hole_ctr  = '0;
    hole_rad  = '0;
    red_dlt   = '0;
    green_dlt = '0;
    blue_dlt  = '0;
    strength  = elr_pkg::STRENGTH_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // All radii are zero after reset, so every pixel must pass unchanged.
    queue_pixel(0, 0, 32'h0000_0000);
    queue_pixel(SCREEN_W - 1, SCREEN_H - 1, 32'hFFFF_FFFF);
    queue_pixel(SCREEN_W - 1, 0, 32'h5A5A_A5A5);
    queue_pixel(0, SCREEN_H - 1, 32'hA5A5_5A5A);
    queue_pixel(512, 512, 32'h0180_40C0);
    drain_results();

    // Concentric ring with mixed lift and drop.
    load_setting({12'd384, 12'd512}, {11'd200, 11'd300}, {12'd384, 12'd512},
                 {11'd60, 11'd100}, 9'd100, -9'sd100, 9'd50, 8'd100);
    queue_probes();
    drain_results();

    // Extreme centers, radii, deltas and strength; every channel saturates.
    load_setting({12'h7FF, 12'h7FF}, 22'h3F_FFFF, {12'h800, 12'h800}, 22'h3F_FFFF,
                 9'h0FF, 9'h100, 9'h101, 8'd255);
    queue_probes();
    drain_results();

    // Zero strength: the ring is found but nothing changes.
    load_setting({12'd200, 12'd700}, {11'd180, 11'd150}, {12'd200, 12'd700},
                 {11'd50, 11'd40}, 9'h0FF, 9'h100, 9'h0AA, 8'd0);
    queue_probes();
    drain_results();

    // Hole that pokes out past the outer ellipse.
    load_setting({12'd300, 12'd300}, {11'd100, 11'd150}, {12'd300, 12'd420},
                 {11'd150, 11'd120}, 9'd200, -9'sd50, 9'd10, 8'd150);
    queue_probes();
    drain_results();

    // Zero hole radius disables the whole effect.
    load_setting({12'd500, 12'd500}, {11'd300, 11'd300}, {12'd500, 12'd500},
                 {11'd40, 11'd0}, 9'd60, 9'd60, 9'd60, 8'd100);
    queue_probes();
    drain_results();

    // Smallest radii at the screen edge.
    load_setting({12'd10, 12'd1000}, {11'd1, 11'd1}, {12'd9, 12'd1000}, {11'd1, 11'd1},
                 -9'sd1, 9'd1, 9'd99, 8'd100);
    queue_probes();
    drain_results();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      or_n = random_radii();
      oc_n = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                          : {12'($urandom_range(0, 1023)),
                                             12'($urandom_range(0, 1023))};
      cx = $signed(oc_n[11:0]);
      cy = $signed(oc_n[23:12]);
      if ($urandom_range(0, 3) != 0) begin
        // Hole near the middle of the outer ellipse, mostly smaller than it.
        ic_n = {12'(cy + int'($urandom_range(0, 80)) - 40),
                12'(cx + int'($urandom_range(0, 80)) - 40)};
        ir_n = {11'($urandom_range(1, 200)), 11'($urandom_range(1, 200))};
      end else begin
        ic_n = 24'($urandom);
        ir_n = random_radii();
      end
      sel  = $urandom_range(0, 5);
      st_n = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : (sel == 2) ? 8'd100 : 8'($urandom);
      load_setting(oc_n, or_n, ic_n, ir_n, random_delta(), random_delta(), random_delta(),
                   st_n);

      ox  = int'(outer_rad[10:0]) + 2;
      oy  = int'(outer_rad[21:11]) + 2;
      hx  = $signed(hole_ctr[11:0]);
      hy  = $signed(hole_ctr[23:12]);
      hox = int'(hole_rad[10:0]) + 2;
      hoy = int'(hole_rad[21:11]) + 2;
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 6)
          queue_pixel(cx + int'($urandom_range(0, 2 * ox)) - ox,
                      cy + int'($urandom_range(0, 2 * oy)) - oy, random_color());
        else if (sel < 8)
          queue_pixel(hx + int'($urandom_range(0, 2 * hox)) - hox,
                      hy + int'($urandom_range(0, 2 * hoy)) - hoy, random_color());
        else
          queue_pixel($urandom_range(0, SCREEN_W - 1), $urandom_range(0, SCREEN_H - 1),
                      random_color());
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: elliptic_ring_light_blend.f
hdl/elr_pkg.sv
hdl/elr_regs.sv
hdl/elr_gain.sv
hdl/elr_span.sv
hdl/elliptic_ring_light_blend.sv
dv/elliptic_ring_light_blend_test.sv
